// File: rtl/brf_pkg.sv
// Shared types, codes and helpers of the bitmap rectangle fill block.
package brf_pkg;

   localparam int COORD_W = 12;
   localparam int ADDR_FIELD_W = 13;
   localparam int PROD_W = 2 * COORD_W + 1;

   localparam logic [1:0] OP_FILL  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [COORD_W-1:0] BITMAP_WIDTH_RESET = 12'd256;

   typedef struct packed {
      logic [1:0]              operation;
      logic [COORD_W-1:0]      rect_x;
      logic [COORD_W-1:0]      rect_y;
      logic [COORD_W-1:0]      rect_w;
      logic [COORD_W-1:0]      rect_h;
      logic [ADDR_FIELD_W-1:0] byte_address;
      logic [7:0]              write_data;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       fill_ignored;
   } rsp_payload_type;

   // Bits lo .. hi-1 of one byte, 0 <= lo <= hi <= 8.
   function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [3:0] hi);
      logic [8:0] upper;
      logic [7:0] lower;
      upper = 9'((9'd1 << hi) - 9'd1);
      lower = 8'((8'd1 << lo) - 8'd1);
      return upper[7:0] & ~lower;
   endfunction

endpackage

// File: rtl/bitmap_rectangle_fill_core.sv
// One-bit-per-pixel bitmap store with rectangle fill and byte access.
//
// Channels: req_* carries one item (fill rectangle, read byte, write byte) and
// transfers when req_valid and req_ready are both high; rsp_* returns exactly
// one result per item (read_data, fill_ignored) under the same handshake.
// csr_write_enable/csr_write_data load the bitmap width register (pixels).
//
// The block works on one item at a time; req_ready is high only while the
// sequencer is idle. A byte-wide store with one write port and one registered
// read port carries all the work. A read passes through ST_READ and ST_RDATA,
// a write through ST_WRITE; an unused code, an out-of-range byte address or a
// skipped fill goes straight to ST_DONE. A fill runs ST_MUL, then for each row
// ST_ROW and ST_SPAN, then one ST_BYTE step per byte touched plus an ST_MODIFY
// step for each partial head or tail byte (read-modify-write); whole bytes are
// written without a read; a fill stops at the first row starting past the store.
//
// Reset clears the control state and then runs a clearing pass over the
// store, one byte per cycle, with req_ready low; the width register can be
// written meanwhile. The result sits in an output register, so a new item is
// accepted while rsp_valid waits on a stalled receiver; only the next finished
// result waits for that register to drain.
module bitmap_rectangle_fill_core #(
   parameter int STORE_BYTES = 8192
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  brf_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output brf_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [brf_pkg::COORD_W-1:0] csr_write_data
);

   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int LIMIT_BITS = STORE_BYTES * 8;
   localparam int SPAN_W = $clog2(LIMIT_BITS + 3 * 4096) + 1;
   // Bit position width: holds y * width and limit plus a few coordinates.
   localparam int POS_W = (SPAN_W > brf_pkg::PROD_W) ? SPAN_W : brf_pkg::PROD_W;
   localparam int BYTE_W = POS_W - 3;
   localparam logic [POS_W-1:0] LIMIT = POS_W'(LIMIT_BITS);
   localparam logic [POS_W-1:0] LIMIT_M1 = POS_W'(LIMIT_BITS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_ROW,
      ST_SPAN,
      ST_BYTE,
      ST_MODIFY,
      ST_WRITE,
      ST_READ,
      ST_RDATA,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [ADDR_W-1:0]              clr_ff, clr_in;
   logic [brf_pkg::COORD_W-1:0]    bitmap_width_ff, bitmap_width_in;
   logic [brf_pkg::COORD_W-1:0]    x_ff, x_in;
   logic [brf_pkg::COORD_W-1:0]    y_ff, y_in;
   logic [brf_pkg::COORD_W-1:0]    wm1_ff, wm1_in;
   logic [brf_pkg::COORD_W-1:0]    rows_left_ff, rows_left_in;
   logic [POS_W-1:0]               row_base_ff, row_base_in;
   logic [POS_W-1:0]               run_start_ff, run_start_in;
   logic [BYTE_W-1:0]              byte_ff, byte_in;
   logic [BYTE_W-1:0]              last_byte_ff, last_byte_in;
   logic [2:0]                     lo_ff, lo_in;
   logic [3:0]                     hi_ff, hi_in;
   logic                           head_ff, head_in;
   logic [7:0]                     mask_ff, mask_in;
   logic [7:0]                     wdata_ff, wdata_in;
   brf_pkg::rsp_payload_type       result_ff, result_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   brf_pkg::rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic [7:0]                     pixel_store_ff [STORE_BYTES];
   logic [7:0]                     rdata_ff;
   logic                           mem_we;
   logic [ADDR_W-1:0]              mem_waddr;
   logic [7:0]                     mem_wdata;

   logic [2*brf_pkg::COORD_W-1:0]  prod;
   logic [POS_W-1:0]               start_sum;
   logic [POS_W-1:0]               last_sum;
   logic [POS_W-1:0]               last_clamp;
   logic                           at_last;
   logic [7:0]                     cur_mask;
   logic                           addr_ok;
   logic                           req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign prod = y_ff * bitmap_width_ff;
   assign start_sum = row_base_ff + POS_W'(x_ff);
   assign last_sum = run_start_ff + POS_W'(wm1_ff);
   assign last_clamp = (last_sum > LIMIT_M1) ? LIMIT_M1 : last_sum;
   assign at_last = (byte_ff == last_byte_ff);
   assign cur_mask = brf_pkg::span_mask(head_ff ? lo_ff : 3'd0, at_last ? hi_ff : 4'd8);
   assign addr_ok = (32'(req_payload.byte_address) < 32'(STORE_BYTES));

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      bitmap_width_in = csr_write_enable ? csr_write_data : bitmap_width_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      wm1_in          = wm1_ff;
      rows_left_in    = rows_left_ff;
      row_base_in     = row_base_ff;
      run_start_in    = run_start_ff;
      byte_in         = byte_ff;
      last_byte_in    = last_byte_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      head_in         = head_ff;
      mask_in         = mask_ff;
      wdata_in        = wdata_ff;
      result_in       = result_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_payload_in  = rsp_payload_ff;
      mem_we          = 1'b0;
      mem_waddr       = byte_ff[ADDR_W-1:0];
      mem_wdata       = 8'h00;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep the store to zero, one byte per cycle.
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               x_in         = req_payload.rect_x;
               y_in         = req_payload.rect_y;
               wm1_in       = req_payload.rect_w - 1'b1;
               rows_left_in = req_payload.rect_h;
               byte_in      = BYTE_W'(req_payload.byte_address);
               wdata_in     = req_payload.write_data;
               result_in    = '0;
               state_in     = ST_DONE;
               unique case (req_payload.operation)
                  brf_pkg::OP_FILL: begin
                     if (bitmap_width_ff[2:0] != 3'd0) begin
                        result_in.fill_ignored = 1'b1;
                     end else if (req_payload.rect_w != '0) begin
                        state_in = ST_MUL;
                     end
                  end
                  brf_pkg::OP_READ: begin
                     if (addr_ok) begin
                        state_in = ST_READ;
                     end
                  end
                  brf_pkg::OP_WRITE: begin
                     if (addr_ok) begin
                        state_in = ST_WRITE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            // First row's bit position: y times the row pitch in bits.
            row_base_in = POS_W'(prod);
            state_in    = ST_ROW;
         end
         ST_ROW: begin
            if (rows_left_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               run_start_in = start_sum;
               row_base_in  = row_base_ff + POS_W'(bitmap_width_ff);
               rows_left_in = rows_left_ff - 1'b1;
               state_in     = ST_SPAN;
            end
         end
         ST_SPAN: begin
            // Stop at the first run that starts past the store.
            if (run_start_ff >= LIMIT) begin
               state_in = ST_DONE;
            end else begin
               byte_in      = run_start_ff[POS_W-1:3];
               last_byte_in = last_clamp[POS_W-1:3];
               lo_in        = run_start_ff[2:0];
               hi_in        = {1'b0, last_clamp[2:0]} + 4'd1;
               head_in      = 1'b1;
               state_in     = ST_BYTE;
            end
         end
         ST_BYTE: begin
            head_in = 1'b0;
            if (cur_mask == 8'hff) begin
               // Whole byte: write without a read.
               mem_we    = 1'b1;
               mem_wdata = 8'hff;
               if (at_last) begin
                  state_in = ST_ROW;
               end else begin
                  byte_in = byte_ff + 1'b1;
               end
            end else begin
               // Partial byte: read issued now, merge next cycle.
               mask_in  = cur_mask;
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff | mask_ff;
            if (at_last) begin
               state_in = ST_ROW;
            end else begin
               byte_in  = byte_ff + 1'b1;
               state_in = ST_BYTE;
            end
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = wdata_ff;
            state_in  = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            result_in.read_data = rdata_ff;
            state_in            = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = result_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         bitmap_width_ff <= brf_pkg::BITMAP_WIDTH_RESET;
         head_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         bitmap_width_ff <= bitmap_width_in;
         head_ff         <= head_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      x_ff           <= x_in;
      y_ff           <= y_in;
      wm1_ff         <= wm1_in;
      rows_left_ff   <= rows_left_in;
      row_base_ff    <= row_base_in;
      run_start_ff   <= run_start_in;
      byte_ff        <= byte_in;
      last_byte_ff   <= last_byte_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mask_ff        <= mask_in;
      wdata_ff       <= wdata_in;
      result_ff      <= result_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // Byte store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_store_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= pixel_store_ff[byte_ff[ADDR_W-1:0]];
   end

`ifndef NO_ASSERTIONS
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < 32'(STORE_BYTES)))
      else $error("store write beyond last byte");

   a_modify_partial: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> (mask_ff != 8'hff && mask_ff != 8'h00))
      else $error("read-modify-write on a whole or empty byte");

   a_fill_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BYTE) |-> (bitmap_width_ff[2:0] == 3'd0))
      else $error("fill running with unaligned bitmap width");

   a_byte_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BYTE || state_ff == ST_MODIFY) |-> (byte_ff <= last_byte_ff))
      else $error("byte walk passed the end of the run");
`endif

endmodule
